@@ hdl/icu_pkg.sv @@
// ============================================================================
// icu_pkg
// Shared types and constants of the integer calculator unit.
// ============================================================================
package icu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(DATA_WIDTH + 1);
    // From this argument on the factorial holds 2^DATA_WIDTH as a factor
    localparam int FACT_LIMIT  = 2 * DATA_WIDTH;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_FACT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_NEG_ARG  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new transaction and set up the operation
        logic step;   // run one iteration of the current operation
        logic store;  // write the finished result to the output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic done;   // operation complete, result ready to store
    } dp_stat_t;

endpackage

@@ hdl/integer_calculator_unit.sv @@
// ============================================================================
// integer_calculator_unit
// Signed 32-bit calculator: add, subtract, multiply, divide, power, factorial.
// ============================================================================
// One transaction in gives one result transaction out. Add, subtract and
// multiply are computed at acceptance and stored once the output register
// is free. Divide runs a restoring divider, one quotient bit per cycle.
// Power uses square-and-multiply, one exponent bit per cycle. Factorial
// multiplies by one index per cycle; arguments of 64 and above finish
// without iterating, with a result of zero. Multiply, power and factorial
// share one 32x32 multiplier. One transaction is in work at a time; a new
// one is accepted as soon as the previous result sits in the output
// register, even while that result still waits to be taken. Error cases
// (zero divisor, negative exponent, negative factorial argument) finish
// without iterating, with zero outputs and a nonzero status; unused command
// codes give zeros.
// ============================================================================
module integer_calculator_unit
    import icu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic signed [DATA_WIDTH-1:0] remainder_value,
    output logic [1:0]                   status
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequence load, iterate and store; own the output valid flag
    icu_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // Hold operands, run the arithmetic and drive the output payload
    icu_datapath u_dp (
        .clk             (clk),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .command         (command),
        .operand_a       (operand_a),
        .operand_b       (operand_b),
        .result          (result),
        .remainder_value (remainder_value),
        .status          (status)
    );

    // An error result always carries zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DIV_ZERO || status == ST_NEG_ARG))
            |-> (result == '0 && remainder_value == '0))
    else $error("error status with nonzero payload");

    // One transaction in work at a time: no acceptance right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in work");

    // A freshly accepted transaction cannot produce its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared before the datapath ran");

    // A remainder is only reported for a successful divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && remainder_value != '0) |-> (status == ST_OK))
    else $error("remainder reported with error status");

endmodule

@@ hdl/icu_datapath.sv @@
// ============================================================================
// icu_datapath
// Operand registers, shared multiplier, restoring divider and output register.
// ============================================================================
module icu_datapath
    import icu_pkg::*;
(
    input  logic                         clk,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    input  logic [2:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic signed [DATA_WIDTH-1:0] remainder_value,
    output logic [1:0]                   status
);

    localparam int W = DATA_WIDTH;

    op_t            op_reg, op_next;
    status_t        err_reg, err_next;
    logic [W-1:0]   acc_reg, acc_next;    // sum, product, power or factorial
    logic [W-1:0]   sq_reg, sq_next;      // square, factorial index or remainder
    logic [W-1:0]   e_reg, e_next;        // exponent, factorial limit or quotient
    logic [W-1:0]   d_reg, d_next;        // divisor magnitude
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           neg_q_reg, neg_q_next;
    logic           neg_r_reg, neg_r_next;

    logic [W-1:0]   result_reg, result_next;
    logic [W-1:0]   rem_reg, rem_next;
    status_t        status_reg, status_next;

    logic [W-1:0]   a_u, b_u, a_mag, b_mag;
    logic [W-1:0]   mul_x, mul_y, mul_p, sq_p;
    logic [W:0]     rem_shift, trial;

    assign a_u   = W'($unsigned(operand_a));
    assign b_u   = W'($unsigned(operand_b));
    assign a_mag = a_u[W-1] ? (W'(0) - a_u) : a_u;
    assign b_mag = b_u[W-1] ? (W'(0) - b_u) : b_u;

    // One shared multiplier: operands at load, accumulator times square/index after
    assign mul_x = cmd.load ? a_u : acc_reg;
    assign mul_y = cmd.load ? b_u : sq_reg;
    assign mul_p = mul_x * mul_y;
    assign sq_p  = sq_reg * sq_reg;

    // Restoring division: shift the next dividend bit into the partial remainder
    assign rem_shift = {sq_reg, e_reg[W-1]};
    assign trial     = rem_shift - {1'b0, d_reg};

    always_comb
    begin
        stat.done = 1'b1;
        if (err_reg == ST_OK)
        begin
            case (op_reg)
                OP_DIV:  stat.done = (cnt_reg == '0);
                OP_POW:  stat.done = (e_reg == '0);
                OP_FACT: stat.done = (sq_reg > e_reg);
                default: stat.done = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        op_next    = op_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        cnt_next   = cnt_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        if (cmd.load)
        begin
            op_next    = op_t'(command);
            err_next   = ST_OK;
            acc_next   = '0;
            sq_next    = '0;
            e_next     = '0;
            d_next     = '0;
            cnt_next   = '0;
            neg_q_next = a_u[W-1] ^ b_u[W-1];
            neg_r_next = a_u[W-1];
            case (op_t'(command))
                OP_ADD: acc_next = a_u + b_u;
                OP_SUB: acc_next = a_u - b_u;
                OP_MUL: acc_next = mul_p;
                OP_DIV:
                begin
                    if (b_u == '0)
                        err_next = ST_DIV_ZERO;
                    else
                    begin
                        e_next   = a_mag;
                        d_next   = b_mag;
                        cnt_next = CNT_W'(W);
                    end
                end
                OP_POW:
                begin
                    if (b_u[W-1])
                        err_next = ST_NEG_ARG;
                    else
                    begin
                        acc_next = W'(1);
                        sq_next  = a_u;
                        e_next   = b_u;
                    end
                end
                OP_FACT:
                begin
                    if (a_u[W-1])
                        err_next = ST_NEG_ARG;
                    else
                    begin
                        sq_next = W'(2);
                        if (a_u >= W'(FACT_LIMIT))
                            e_next = '0;        // product wraps to zero
                        else
                        begin
                            acc_next = W'(1);
                            e_next   = a_u;
                        end
                    end
                end
                default: acc_next = '0;
            endcase
        end
        else if (cmd.step)
        begin
            case (op_reg)
                OP_DIV:
                begin
                    if (!trial[W])
                    begin
                        sq_next = trial[W-1:0];
                        e_next  = {e_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_next = rem_shift[W-1:0];
                        e_next  = {e_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                OP_POW:
                begin
                    if (e_reg[0])
                        acc_next = mul_p;
                    sq_next = sq_p;
                    e_next  = e_reg >> 1;
                end
                OP_FACT:
                begin
                    acc_next = mul_p;
                    sq_next  = sq_reg + W'(1);
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        result_next = result_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        if (cmd.store)
        begin
            status_next = err_reg;
            if (err_reg != ST_OK)
            begin
                result_next = '0;
                rem_next    = '0;
            end
            else if (op_reg == OP_DIV)
            begin
                result_next = neg_q_reg ? (W'(0) - e_reg) : e_reg;
                rem_next    = neg_r_reg ? (W'(0) - sq_reg) : sq_reg;
            end
            else
            begin
                result_next = acc_reg;
                rem_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        err_reg    <= err_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        d_reg      <= d_next;
        cnt_reg    <= cnt_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        result_reg <= result_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
    end

    assign result          = $signed(result_reg);
    assign remainder_value = $signed(rem_reg);
    assign status          = status_reg;

endmodule

@@ hdl/icu_controller.sv @@
// ============================================================================
// icu_controller
// Sequencer for load, iterate and store, plus the output valid flag.
// ============================================================================
module icu_controller
    import icu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Output register can take a result if empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (stat.done && slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        cmd.store = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_RUN:
            begin
                cmd.step  = !stat.done;
                cmd.store = stat.done && slot_free;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
